>>> rtl/lpmr_pkg.sv
package lpmr_pkg;

  localparam int MSG_BUF_SIZE_DEF = 1024;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QUEUE_PTR_W      = $clog2(QUEUE_DEPTH);
  localparam int POS_W            = 10;
  localparam int LEN_W            = 16;
  localparam int OUT_TDATA_W      = 40;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2,
    PH_HELD  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0] message_length;
    logic             large_message;
    logic             message_done;
    logic             segment_full;
    logic [7:0]       store_byte;
    logic [POS_W-1:0] store_position;
    logic             store_valid;
    logic             accepted;
  } result_t;

endpackage

>>> rtl/lpmr_front.sv
module lpmr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic [0:0]           s_tuser,
  output lpmr_pkg::queue_head_t head,
  input  logic                 pop
);

  localparam int CNT_W = $clog2(lpmr_pkg::QUEUE_DEPTH + 1);

  lpmr_pkg::cmd_t                       mem [lpmr_pkg::QUEUE_DEPTH];
  logic [lpmr_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [lpmr_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [CNT_W-1:0]                     count;
  lpmr_pkg::cmd_t                       cmd_in;
  logic                                 push;
  logic                                 do_pop;

  always_comb begin
    cmd_in.kind      = s_tuser[0] ? lpmr_pkg::CMD_RELEASE : lpmr_pkg::CMD_BYTE;
    cmd_in.data_byte = s_tdata;
  end

  assign s_tready   = (count != CNT_W'(lpmr_pkg::QUEUE_DEPTH));
  assign push       = s_tvalid && s_tready;
  assign do_pop     = pop && (count != '0);
  assign head.valid = (count != '0);
  assign head.cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == lpmr_pkg::QUEUE_PTR_W'(lpmr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == lpmr_pkg::QUEUE_PTR_W'(lpmr_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/lpmr_back.sv
module lpmr_back #(
  parameter int MSG_BUF_SIZE = lpmr_pkg::MSG_BUF_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lpmr_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lpmr_pkg::result_t     out_result
);

  localparam int FILL_W = $clog2(MSG_BUF_SIZE + 1);
  localparam int SUM_W  = 18;

  lpmr_pkg::phase_t                 phase;
  lpmr_pkg::phase_t                 phase_next;
  logic [7:0]                       header_low_byte;
  logic [7:0]                       header_low_byte_next;
  logic [lpmr_pkg::LEN_W-1:0]       body_remaining;
  logic [lpmr_pkg::LEN_W-1:0]       body_remaining_next;
  logic [lpmr_pkg::LEN_W-1:0]       total_length;
  logic [lpmr_pkg::LEN_W-1:0]       total_length_next;
  logic [FILL_W-1:0]                fill_position;
  logic [FILL_W-1:0]                fill_position_next;
  logic                             large_flag;
  logic                             large_flag_next;
  lpmr_pkg::result_t                result_next;

  logic                             is_byte;
  logic                             is_release;
  logic [FILL_W-1:0]                fill_inc;
  logic [FILL_W+SUM_W-1:0]          fill_ext;
  logic [FILL_W+lpmr_pkg::POS_W-1:0] pos_ext;
  logic [SUM_W-1:0]                 fill_plus_rem;
  logic                             over_free;
  logic [lpmr_pkg::LEN_W-1:0]       rem_dec;
  logic [lpmr_pkg::LEN_W-1:0]       header_len;

  assign pop        = head.valid && (!out_valid || out_ready);
  assign is_byte    = pop && (head.cmd.kind == lpmr_pkg::CMD_BYTE);
  assign is_release = pop && (head.cmd.kind == lpmr_pkg::CMD_RELEASE);

  assign fill_inc      = fill_position + 1'b1;
  assign fill_ext      = {{SUM_W{1'b0}}, fill_position};
  assign pos_ext       = {{lpmr_pkg::POS_W{1'b0}}, fill_position};
  assign fill_plus_rem = fill_ext[SUM_W-1:0] + SUM_W'(body_remaining);
  assign over_free     = fill_plus_rem > SUM_W'(MSG_BUF_SIZE);
  assign rem_dec       = (body_remaining != '0) ? body_remaining - 1'b1 : body_remaining;
  assign header_len    = {head.cmd.data_byte, header_low_byte};

  // phase sequencing
  always_comb begin
    phase_next = phase;
    if (is_release) begin
      if (phase == lpmr_pkg::PH_HELD) begin
        phase_next = large_flag ? lpmr_pkg::PH_BODY : lpmr_pkg::PH_EMPTY;
      end
    end else if (is_byte) begin
      case (phase)
        lpmr_pkg::PH_EMPTY: begin
          phase_next = lpmr_pkg::PH_LEN;
        end
        lpmr_pkg::PH_LEN: begin
          phase_next = (header_len == '0) ? lpmr_pkg::PH_EMPTY : lpmr_pkg::PH_BODY;
        end
        lpmr_pkg::PH_BODY: begin
          if (rem_dec == '0 || fill_inc >= FILL_W'(MSG_BUF_SIZE)) begin
            phase_next = lpmr_pkg::PH_HELD;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // counters and result
  always_comb begin
    header_low_byte_next = header_low_byte;
    body_remaining_next  = body_remaining;
    total_length_next    = total_length;
    fill_position_next   = fill_position;
    large_flag_next      = large_flag;
    result_next          = '0;
    result_next.accepted = 1'b1;

    if (is_release) begin
      if (phase == lpmr_pkg::PH_HELD) begin
        fill_position_next = '0;
      end
    end else if (is_byte) begin
      if (phase == lpmr_pkg::PH_HELD) begin
        result_next.accepted = 1'b0;
      end else begin
        result_next.store_valid    = 1'b1;
        result_next.store_position = pos_ext[lpmr_pkg::POS_W-1:0];
        result_next.store_byte     = head.cmd.data_byte;
        case (phase)
          lpmr_pkg::PH_EMPTY: begin
            header_low_byte_next = head.cmd.data_byte;
            fill_position_next   = FILL_W'(1);
          end
          lpmr_pkg::PH_LEN: begin
            total_length_next   = header_len;
            body_remaining_next = header_len;
            large_flag_next     = 1'b0;
            fill_position_next  = (header_len == '0) ? '0 : fill_inc;
          end
          default: begin
            fill_position_next  = fill_inc;
            body_remaining_next = rem_dec;
            if (rem_dec == '0) begin
              large_flag_next = 1'b0;
            end else if (fill_inc >= FILL_W'(MSG_BUF_SIZE)) begin
              large_flag_next = 1'b1;
            end else begin
              large_flag_next = over_free;
            end
          end
        endcase
      end
    end

    result_next.segment_full   = (phase_next == lpmr_pkg::PH_HELD) && large_flag_next;
    result_next.message_done   = (phase_next == lpmr_pkg::PH_HELD) && !large_flag_next;
    result_next.large_message  = large_flag_next;
    result_next.message_length = total_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= lpmr_pkg::PH_EMPTY;
      header_low_byte <= '0;
      body_remaining  <= '0;
      total_length    <= '0;
      fill_position   <= '0;
      large_flag      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      phase           <= phase_next;
      header_low_byte <= header_low_byte_next;
      body_remaining  <= body_remaining_next;
      total_length    <= total_length_next;
      fill_position   <= fill_position_next;
      large_flag      <= large_flag_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_result <= result_next;
    end
  end

endmodule

>>> rtl/length_prefixed_message_reassembler.sv
// channel   dir  tdata fields (lsb first)                          tuser
// s_axis    in   data_byte[7:0]                                     req_type
// m_axis    out  accepted, store_valid, store_position[9:0],        -
//                store_byte[7:0], segment_full, message_done,
//                large_message, message_length[15:0], zero pad
// one request a cycle sustained while m_tready keeps up; a request first
// waits in the two-entry queue, then the state update loads the output
// register
// rst clears the phase, counters and queue; no clearing pass
// a stalled m_tready holds the result; the queue keeps taking requests until full
module length_prefixed_message_reassembler #(
  parameter int MSG_BUF_SIZE = lpmr_pkg::MSG_BUF_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [7:0]                          s_tdata,  // data_byte
  input  logic [0:0]                          s_tuser,  // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // accepted, store_valid, store_position, store_byte, segment_full,
  // message_done, large_message, message_length, pad
  output logic [lpmr_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  lpmr_pkg::queue_head_t head;
  logic                  pop;
  lpmr_pkg::result_t     out_result;

  lpmr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .head     (head),
    .pop      (pop)
  );

  lpmr_back #(
    .MSG_BUF_SIZE (MSG_BUF_SIZE)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tdata = {{(lpmr_pkg::OUT_TDATA_W - $bits(lpmr_pkg::result_t)){1'b0}}, out_result};

endmodule

>>> test/tb_length_prefixed_message_reassembler.sv
`timescale 1ns / 100ps

module tb_length_prefixed_message_reassembler;

  localparam int BUF_SIZE     = lpmr_pkg::MSG_BUF_SIZE_DEF;
  localparam int RANDOM_STORES = 120;

  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_PERIODIC,
    RX_SPARSE
  } rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;  // data_byte
  logic [0:0]             s_tuser = 1'b0;   // req_type
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // accepted, store_valid, store_position, store_byte, segment_full,
  // message_done, large_message, message_length, pad
  logic [lpmr_pkg::OUT_TDATA_W-1:0] m_tdata;

  // predictor state
  lpmr_pkg::phase_t pr_phase = lpmr_pkg::PH_EMPTY;
  logic [7:0]  pr_hdr_low    = 8'h00;
  int          pr_body_left  = 0;
  logic [15:0] pr_msg_len    = 16'h0000;
  int          pr_fill_pos   = 0;
  logic        pr_large      = 1'b0;

  lpmr_pkg::result_t pending_results[$];
  int      error_count = 0;
  int      store_count = 0;
  int      burst_left  = 1;
  int      rx_left     = 0;
  int      rx_cycle    = 0;
  rx_mode_t rx_mode    = RX_OPEN;

  length_prefixed_message_reassembler #(
    .MSG_BUF_SIZE(BUF_SIZE)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic lpmr_pkg::result_t predict_store(lpmr_pkg::cmd_kind_t kind,
                                                      logic [7:0] b);
    lpmr_pkg::result_t r;
    int          free_space;
    logic [15:0] len;
    r = '0;
    r.accepted = 1'b1;
    if (kind == lpmr_pkg::CMD_RELEASE) begin
      if (pr_phase == lpmr_pkg::PH_HELD) begin
        pr_fill_pos = 0;
        pr_phase = pr_large ? lpmr_pkg::PH_BODY : lpmr_pkg::PH_EMPTY;
      end
    end else if (pr_phase == lpmr_pkg::PH_HELD) begin
      r.accepted = 1'b0;
    end else begin
      r.store_valid = 1'b1;
      r.store_position = pr_fill_pos[lpmr_pkg::POS_W-1:0];
      r.store_byte = b;
      case (pr_phase)
        lpmr_pkg::PH_EMPTY: begin
          pr_hdr_low = b;
          pr_fill_pos = 1;
          pr_phase = lpmr_pkg::PH_LEN;
        end
        lpmr_pkg::PH_LEN: begin
          len = {b, pr_hdr_low};
          pr_fill_pos = pr_fill_pos + 1;
          pr_msg_len = len;
          pr_body_left = len;
          pr_large = 1'b0;
          if (len == 16'h0000) begin
            pr_fill_pos = 0;
            pr_phase = lpmr_pkg::PH_EMPTY;
          end else begin
            pr_phase = lpmr_pkg::PH_BODY;
          end
        end
        default: begin
          free_space = (pr_fill_pos < BUF_SIZE) ? BUF_SIZE - pr_fill_pos : 0;
          pr_large = (free_space < pr_body_left);
          pr_fill_pos = pr_fill_pos + 1;
          if (pr_body_left > 0) pr_body_left = pr_body_left - 1;
          if (pr_body_left == 0) begin
            pr_large = 1'b0;
            pr_phase = lpmr_pkg::PH_HELD;
          end else if (pr_fill_pos >= BUF_SIZE) begin
            pr_large = 1'b1;
            pr_phase = lpmr_pkg::PH_HELD;
          end
        end
      endcase
    end
    r.segment_full = (pr_phase == lpmr_pkg::PH_HELD) && pr_large;
    r.message_done = (pr_phase == lpmr_pkg::PH_HELD) && !pr_large;
    r.large_message = pr_large;
    r.message_length = pr_msg_len;
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_request(lpmr_pkg::cmd_kind_t kind, logic [7:0] b);
    lpmr_pkg::result_t r;
    int      gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = predict_store(kind, b);
    pending_results.push_back(r);
    if (r.store_valid) store_count++;
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic send_header(int len);
    send_request(lpmr_pkg::CMD_BYTE, len[7:0]);
    send_request(lpmr_pkg::CMD_BYTE, len[15:8]);
  endtask

  // runs the current message to its end, segments and releases included
  task automatic finish_message(int noise_pct);
    while (pr_phase != lpmr_pkg::PH_EMPTY) begin
      if (pr_phase == lpmr_pkg::PH_HELD) begin
        if ($urandom_range(0, 99) < noise_pct)
          send_request(lpmr_pkg::CMD_BYTE, 8'($urandom));
        else
          send_request(lpmr_pkg::CMD_RELEASE, 8'($urandom));
      end else begin
        if ($urandom_range(0, 99) < noise_pct)
          send_request(lpmr_pkg::CMD_RELEASE, 8'($urandom));
        else
          send_request(lpmr_pkg::CMD_BYTE, 8'($urandom));
      end
    end
  endtask

  task automatic test_idle_release();
    send_request(lpmr_pkg::CMD_RELEASE, 8'hFF);
    send_request(lpmr_pkg::CMD_RELEASE, 8'h00);
  endtask

  task automatic test_zero_length();
    send_header(0);
    send_request(lpmr_pkg::CMD_RELEASE, 8'h5A);
  endtask

  task automatic test_short_message();
    send_header(3);
    send_request(lpmr_pkg::CMD_BYTE, 8'h00);
    send_request(lpmr_pkg::CMD_BYTE, 8'hFF);
    send_request(lpmr_pkg::CMD_BYTE, 8'hA5);
    // bytes while held are turned away
    send_request(lpmr_pkg::CMD_BYTE, 8'h00);
    send_request(lpmr_pkg::CMD_BYTE, 8'hFF);
    send_request(lpmr_pkg::CMD_RELEASE, 8'h00);
    send_request(lpmr_pkg::CMD_RELEASE, 8'hFF);
  endtask

  task automatic test_stray_release();
    send_request(lpmr_pkg::CMD_BYTE, 8'h02);
    send_request(lpmr_pkg::CMD_RELEASE, 8'h00);
    send_request(lpmr_pkg::CMD_BYTE, 8'h00);
    send_request(lpmr_pkg::CMD_BYTE, 8'h3C);
    send_request(lpmr_pkg::CMD_RELEASE, 8'hFF);
    send_request(lpmr_pkg::CMD_BYTE, 8'hC3);
    send_request(lpmr_pkg::CMD_RELEASE, 8'h00);
  endtask

  task automatic test_exact_fill();
    send_header(BUF_SIZE - 2);
    finish_message(0);
  endtask

  // one byte more than fits, so a second segment follows at position 0
  task automatic test_segmented_message();
    send_header(BUF_SIZE - 1);
    finish_message(0);
  endtask

  task automatic test_random_messages();
    int target;
    int pick;
    int len;
    target = store_count + RANDOM_STORES;
    while (store_count < target) begin
      if ($urandom_range(0, 19) == 0) send_request(lpmr_pkg::CMD_RELEASE, 8'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 10)      len = 0;
      else if (pick < 70) len = $urandom_range(1, 16);
      else if (pick < 95) len = $urandom_range(17, 64);
      else                len = $urandom_range(65, 300);
      send_request(lpmr_pkg::CMD_BYTE, len[7:0]);
      if ($urandom_range(0, 19) == 0) send_request(lpmr_pkg::CMD_RELEASE, 8'($urandom));
      send_request(lpmr_pkg::CMD_BYTE, len[15:8]);
      finish_message(5);
    end
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_left <= 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 300);
    end
    rx_left--;
    rx_cycle++;
    case (rx_mode)
      RX_OPEN:     m_tready <= 1'b1;
      RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready <= (rx_cycle % 4) != 0;
      default:     m_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    lpmr_pkg::result_t got;
    lpmr_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = lpmr_pkg::result_t'(m_tdata[$bits(lpmr_pkg::result_t)-1:0]);
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none actual 0x%0h", $time, got);
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, got.accepted);
        check_field("store_valid", want.store_valid, got.store_valid);
        check_field("store_position", want.store_position, got.store_position);
        check_field("store_byte", want.store_byte, got.store_byte);
        check_field("segment_full", want.segment_full, got.segment_full);
        check_field("message_done", want.message_done, got.message_done);
        check_field("large_message", want.large_message, got.large_message);
        check_field("message_length", want.message_length, got.message_length);
      end
    end
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_idle_release();
    test_zero_length();
    test_short_message();
    test_stray_release();
    test_exact_fill();
    test_random_messages();
    test_segmented_message();
    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      error_count++;
      $display("%0t: results missing, expected %0d more actual 0", $time,
               pending_results.size());
    end
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> length_prefixed_message_reassembler.f
rtl/lpmr_pkg.sv
rtl/lpmr_front.sv
rtl/lpmr_back.sv
rtl/length_prefixed_message_reassembler.sv
test/tb_length_prefixed_message_reassembler.sv
